// ===== hw/rtl/pawzr_pkg.sv =====
`default_nettype none

package pawzr_pkg;

    // Input command codes carried on the slave tuser.
    typedef enum logic [1:0] {
        CMD_PLATFORM = 2'd0,
        CMD_SLIDE    = 2'd1,
        CMD_QUERY    = 2'd2
    } t_command;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y = 2'd1;

    localparam int COORD_W   = 10;
    localparam int POS_W     = 32;
    localparam int ROT_W     = 32;
    localparam logic [COORD_W-1:0] CENTER_RESET = 10'd512;

    // Radius square root: radicand is (nx^2 + ny^2) << 32, below 2^54.
    localparam int SQ_W       = 54;
    localparam int SQRT_STEPS = 27;
    localparam int RADIUS_W   = 28;
    localparam int CNT_W      = $clog2(SQRT_STEPS);

    // CORDIC datapath widths.
    localparam int ATAN_DEPTH = 24;
    localparam int CORDIC_DEFAULT = 16;
    localparam int XY_W  = 30;
    localparam int Z_W   = 34;
    localparam int ANG_W = 21;
    localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [Z_W-1:0] ANG_ROUND   = 34'sd8192;

    // Rounded divide by ten, eight quotient bits per cycle over five steps.
    localparam int DIV_BITS  = 8;
    localparam int DIV_STEPS = 5;
    localparam int DIV_W     = DIV_BITS * DIV_STEPS;
    localparam int NUM_W     = 34;
    // Numerator bias 5 + 10 * 2^29 keeps the dividend positive.
    localparam logic signed [35:0] NUM_BIAS   = 36'sd5368709125;
    localparam logic signed [32:0] SLIDE_BIAS = 33'sd536870912;
    // Slide bias minus 1.57 in Q16.16 (102892).
    localparam logic signed [32:0] DROP_BIAS  = 33'sd536768020;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_ITER,
        S_ROUND,
        S_DIFF,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic             upd_plat;
        logic             upd_slide;
        logic             load_query;
        logic             init;
        logic             step;
        logic             round_res;
        logic             diff;
        logic             div_step;
        logic             load_out;
        logic [CNT_W-1:0] idx;
    } t_dp_cmd;

    function automatic logic signed [31:0] f_sat32(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    // floor(atan(2^-i) * 2^30)
    function automatic logic [31:0] f_atan_q30(input logic [CNT_W-1:0] i);
        logic [31:0] r;
        case (i)
            5'd0:    r = 32'h3243F6A8;
            5'd1:    r = 32'h1DAC6705;
            5'd2:    r = 32'h0FADBAFC;
            5'd3:    r = 32'h07F56EA6;
            5'd4:    r = 32'h03FEAB76;
            5'd5:    r = 32'h01FFD55B;
            5'd6:    r = 32'h00FFFAAA;
            5'd7:    r = 32'h007FFF55;
            5'd8:    r = 32'h003FFFEA;
            5'd9:    r = 32'h001FFFFD;
            5'd10:   r = 32'h000FFFFF;
            5'd11:   r = 32'h0007FFFF;
            5'd12:   r = 32'h0003FFFF;
            5'd13:   r = 32'h0001FFFF;
            5'd14:   r = 32'h0000FFFF;
            5'd15:   r = 32'h00007FFF;
            5'd16:   r = 32'h00003FFF;
            5'd17:   r = 32'h00001FFF;
            5'd18:   r = 32'h00000FFF;
            5'd19:   r = 32'h000007FF;
            5'd20:   r = 32'h000003FF;
            5'd21:   r = 32'h000001FF;
            5'd22:   r = 32'h000000FF;
            5'd23:   r = 32'h0000007F;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pawzr_ctrl.sv =====
`default_nettype none

module pawzr_ctrl
    import pawzr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_tvalid,
    input  wire logic [1:0] i_command,
    output logic         o_s_tready,
    output logic         o_m_tvalid,
    input  wire logic    i_m_tready,
    output t_dp_cmd      o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             w_accept;

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_valid;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.idx = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_command)
                        CMD_PLATFORM: o_cmd.upd_plat = 1'b1;
                        CMD_SLIDE:    o_cmd.upd_slide = 1'b1;
                        CMD_QUERY: begin
                            o_cmd.load_query = 1'b1;
                            n_state = S_INIT;
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_cnt   = '0;
                n_state = S_ITER;
            end
            S_ITER: begin
                o_cmd.step = 1'b1;
                if (r_cnt == CNT_W'(SQRT_STEPS - 1)) begin
                    n_state = S_ROUND;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ROUND: begin
                o_cmd.round_res = 1'b1;
                n_state = S_DIFF;
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_cnt   = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_DONE: begin
                // Wait here only while the previous result has not been taken.
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_m_tready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.upd_plat, o_cmd.upd_slide, o_cmd.load_query, o_cmd.init,
                  o_cmd.step, o_cmd.round_res, o_cmd.diff, o_cmd.div_step,
                  o_cmd.load_out}))
        else $error("more than one datapath command at once");

    a_query_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_command == CMD_QUERY) |=> (r_state == S_INIT))
        else $error("accepted query did not start the datapath");

    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIFF) |=> (r_state == S_DIV && r_cnt == '0))
        else $error("divider did not start from step zero");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !o_cmd.load_out)
        else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/pawzr_dp.sv =====
`default_nettype none

module pawzr_dp
    import pawzr_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_dp_cmd              i_cmd,
    input  wire logic signed [POS_W-1:0] i_position,
    input  wire logic [COORD_W-1:0]   i_target_x,
    input  wire logic [COORD_W-1:0]   i_target_y,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data,
    output logic signed [ROT_W-1:0]   o_platform_rotation,
    output logic signed [ROT_W-1:0]   o_color_slide_rotation,
    output logic signed [ROT_W-1:0]   o_drop_slide_rotation
);

    localparam int CORDIC_N = (CORDIC_ITERATIONS > ATAN_DEPTH) ? ATAN_DEPTH
                                                               : CORDIC_ITERATIONS;
    localparam logic [SQ_W-1:0] BIT_INIT = {2'b01, {(SQ_W-2){1'b0}}};

    // Configuration and axis state.
    logic [COORD_W-1:0]      r_center_x, r_center_y;
    logic signed [POS_W-1:0] r_plat_ref, r_plat_off, r_slide_ref, r_slide_off;

    // Query working registers.
    logic signed [COORD_W:0] r_nx, r_ny;
    logic [SQ_W-1:0]         r_rem, r_res, r_bit;
    logic signed [XY_W-1:0]  r_x, r_y;
    logic signed [Z_W-1:0]   r_z;
    logic                    r_zero;
    logic [RADIUS_W-1:0]     r_radius;
    logic signed [ANG_W-1:0] r_angle;
    logic signed [ROT_W-1:0] r_plat;
    logic [DIV_W-1:0]        r_dq;
    logic [3:0]              r_rdiv;

    logic signed [21:0]      w_sqx, w_sqy;
    logic [21:0]             w_r2;
    logic signed [XY_W-1:0]  w_x0, w_y0;
    logic [SQ_W-1:0]         w_trial;
    logic                    w_take;
    logic signed [XY_W-1:0]  w_xs, w_ys;
    logic signed [Z_W-1:0]   w_atan, w_zr, w_ang;
    logic                    w_cordic_en;
    logic signed [35:0]      w_d, w_num;
    logic signed [32:0]      w_pd, w_q, w_slide, w_drop;
    logic signed [32:0]      w_plat_diff, w_slide_diff;
    logic [DIV_BITS-1:0]     w_qbits;
    logic [3:0]              w_rdiv;

    // Center config registers and the two zero-reference axes.
    assign w_plat_diff  = {i_position[POS_W-1], i_position} - {r_plat_ref[POS_W-1], r_plat_ref};
    assign w_slide_diff = {i_position[POS_W-1], i_position}
                        - {r_slide_ref[POS_W-1], r_slide_ref};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x  <= CENTER_RESET;
            r_center_y  <= CENTER_RESET;
            r_plat_ref  <= '0;
            r_plat_off  <= '0;
            r_slide_ref <= '0;
            r_slide_off <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_CENTER_X: r_center_x <= i_cfg_data;
                    CFG_CENTER_Y: r_center_y <= i_cfg_data;
                    default: ;
                endcase
            end
            // A reference of zero latches the reading, whose offset is then zero.
            if (i_cmd.upd_plat) begin
                if (r_plat_ref == '0) begin
                    r_plat_ref <= i_position;
                    r_plat_off <= '0;
                end else begin
                    r_plat_off <= f_sat32(w_plat_diff);
                end
            end
            if (i_cmd.upd_slide) begin
                if (r_slide_ref == '0) begin
                    r_slide_ref <= i_position;
                    r_slide_off <= '0;
                end else begin
                    r_slide_off <= f_sat32(w_slide_diff);
                end
            end
        end
    end

    // Setup arithmetic.
    assign w_sqx = r_nx * r_nx;
    assign w_sqy = r_ny * r_ny;
    assign w_r2  = $unsigned(w_sqx) + $unsigned(w_sqy);
    assign w_x0  = {{(XY_W-COORD_W-17){r_nx[COORD_W]}}, r_nx, 16'd0};
    assign w_y0  = {{(XY_W-COORD_W-17){r_ny[COORD_W]}}, r_ny, 16'd0};

    // One square root digit per iteration; a CORDIC rotation only while idx < CORDIC_N.
    assign w_trial     = r_res + r_bit;
    assign w_take      = (r_rem >= w_trial);
    assign w_xs        = r_x >>> i_cmd.idx;
    assign w_ys        = r_y >>> i_cmd.idx;
    assign w_atan      = $signed({2'b00, f_atan_q30(i_cmd.idx)});
    assign w_cordic_en = (int'(i_cmd.idx) < CORDIC_N);

    assign w_zr  = r_z + ANG_ROUND;
    assign w_ang = w_zr >>> 14;

    assign w_d   = $signed({8'd0, r_radius}) - $signed({{4{r_slide_off[POS_W-1]}}, r_slide_off});
    assign w_num = $signed({w_d[34:0], 1'b0}) + NUM_BIAS;
    assign w_pd  = $signed({{(33-ANG_W){r_angle[ANG_W-1]}}, r_angle})
                 - $signed({r_plat_off[POS_W-1], r_plat_off});

    // Eight restoring steps of the divide by ten; the remainder stays below ten.
    always_comb begin
        logic [3:0] v_rem;
        logic [4:0] v_t;
        v_rem   = r_rdiv;
        w_qbits = '0;
        for (int k = DIV_BITS - 1; k >= 0; k--) begin
            v_t = {v_rem, r_dq[DIV_W-DIV_BITS+k]};
            if (v_t >= 5'd10) begin
                v_rem      = 4'(v_t - 5'd10);
                w_qbits[k] = 1'b1;
            end else begin
                v_rem      = v_t[3:0];
                w_qbits[k] = 1'b0;
            end
        end
        w_rdiv = v_rem;
    end

    assign w_q     = $signed({1'b0, r_dq[31:0]});
    assign w_slide = w_q - SLIDE_BIAS;
    assign w_drop  = w_q - DROP_BIAS;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_query) begin
            r_nx <= $signed({1'b0, i_target_x}) - $signed({1'b0, r_center_x});
            r_ny <= $signed({1'b0, i_target_y}) - $signed({1'b0, r_center_y});
        end
        if (i_cmd.init) begin
            r_rem  <= {w_r2, 32'd0};
            r_res  <= '0;
            r_bit  <= BIT_INIT;
            r_zero <= (r_ny == '0) && (r_nx <= 0);
            // Left half plane is first rotated by a quarter turn.
            if (r_nx < 0) begin
                if (r_ny > 0) begin
                    r_x <= w_y0;
                    r_y <= -w_x0;
                    r_z <= HALF_PI_Q30;
                end else begin
                    r_x <= -w_y0;
                    r_y <= w_x0;
                    r_z <= -HALF_PI_Q30;
                end
            end else begin
                r_x <= w_x0;
                r_y <= w_y0;
                r_z <= '0;
            end
        end
        if (i_cmd.step) begin
            if (w_take) begin
                r_rem <= r_rem - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            if (w_cordic_en) begin
                if (!r_y[XY_W-1]) begin
                    r_x <= r_x + w_ys;
                    r_y <= r_y - w_xs;
                    r_z <= r_z + w_atan;
                end else begin
                    r_x <= r_x - w_ys;
                    r_y <= r_y + w_xs;
                    r_z <= r_z - w_atan;
                end
            end
        end
        if (i_cmd.round_res) begin
            r_radius <= (r_rem > r_res) ? r_res[RADIUS_W-1:0] + 1'b1 : r_res[RADIUS_W-1:0];
            r_angle  <= r_zero ? '0 : w_ang[ANG_W-1:0];
        end
        if (i_cmd.diff) begin
            r_dq   <= {{(DIV_W-NUM_W){1'b0}}, w_num[NUM_W-1:0]};
            r_rdiv <= '0;
            r_plat <= f_sat32(w_pd);
        end
        if (i_cmd.div_step) begin
            r_dq   <= {r_dq[DIV_W-DIV_BITS-1:0], w_qbits};
            r_rdiv <= w_rdiv;
        end
        if (i_cmd.load_out) begin
            o_platform_rotation    <= r_plat;
            o_color_slide_rotation <= f_sat32(w_slide);
            o_drop_slide_rotation  <= f_sat32(w_drop);
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/polar_aim_with_zero_reference_top.sv =====
`default_nettype none

// Polar aim block with latched zero references.
// Slave stream: tuser is the command (0 platform update, 1 slide update,
// 2 aim query, 3 ignored); tdata carries the motor position and target point.
// An update transfer produces no result; the first nonzero position seen on an
// axis becomes its zero reference.
// A query transfer produces one master transfer holding the platform, color
// slide and drop slide rotations, signed Q16.16 and saturated.
// After a query transfer the block runs setup, 27 steps of the shared square
// root / CORDIC iteration loop (set by the one-bit-per-step radius root),
// rounding, offset subtract and five divide-by-ten steps, then loads the output.
// The block works on one query at a time and takes no new transfer until it is
// done; updates are taken every cycle while no query is in flight.
// A finished result sits in the output register; if the receiver stalls, the
// block keeps taking updates and stops only when a second result is ready.
// Configuration writes (center x, center y) are always ready; the user must issue
// them while the block is idle, as the block itself does not enforce this.
// Reset (synchronous, active low) sets both centers to 512, clears references
// and offsets, and drops any pending result.

module polar_aim_with_zero_reference_top
    import pawzr_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = CORDIC_DEFAULT
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // [31:0] motor_position, [41:32] target_x, [51:42] target_y, [55:52] zero
    input  wire logic [55:0]          s_axis_tdata,
    // [1:0] command
    input  wire logic [1:0]           s_axis_tuser,
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // [31:0] platform_rotation, [63:32] color_slide_rotation,
    // [95:64] drop_slide_rotation
    output logic [95:0]               m_axis_tdata,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [COORD_W-1:0]   i_cfg_data
);

    t_dp_cmd                 w_cmd;
    logic signed [ROT_W-1:0] w_plat, w_color, w_drop;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {w_drop, w_color, w_plat};

    pawzr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .i_command  (s_axis_tuser),
        .o_s_tready (s_axis_tready),
        .o_m_tvalid (m_axis_tvalid),
        .i_m_tready (m_axis_tready),
        .o_cmd      (w_cmd)
    );

    pawzr_dp #(
        .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
    ) u_dp (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cmd                  (w_cmd),
        .i_position             ($signed(s_axis_tdata[31:0])),
        .i_target_x             (s_axis_tdata[41:32]),
        .i_target_y             (s_axis_tdata[51:42]),
        .i_cfg_we               (i_cfg_valid && o_cfg_ready),
        .i_cfg_index            (i_cfg_index),
        .i_cfg_data             (i_cfg_data),
        .o_platform_rotation    (w_plat),
        .o_color_slide_rotation (w_color),
        .o_drop_slide_rotation  (w_drop)
    );

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import pawzr_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int DRAIN_CYCLES = 48;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_PHASES = 6;
    localparam int ITEMS_PER_PHASE = 104;

    // Command code that the block does not decode, and register indexes it ignores.
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    localparam longint Q16_MAX = 2147483647;
    localparam longint Q16_MIN = -Q16_MAX - 1;
    localparam longint RIGHT_ANGLE_Q30 = 1686629713;
    localparam longint DROP_OFFSET_Q16 = 102892;

    typedef struct packed {
        logic [1:0]         cmd;
        logic signed [31:0] pos;
        logic [9:0]         tx;
        logic [9:0]         ty;
    } t_aim_item;

    typedef struct packed {
        logic [31:0] platform;
        logic [31:0] color;
        logic [31:0] drop;
    } t_aim_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [55:0] s_axis_tdata = '0;
    logic [1:0] s_axis_tuser = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [COORD_W-1:0] i_cfg_data = '0;

    always #4 i_clk = ~i_clk;

    polar_aim_with_zero_reference_top #(
        .CORDIC_ITERATIONS(CORDIC_STEPS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data(i_cfg_data)
    );

    longint atan_lut [0:23] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
        64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
        64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
        64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
        64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
    };

    // Shadow of the block's configuration and zero-reference state.
    logic [COORD_W-1:0] model_center_x = CENTER_RESET;
    logic [COORD_W-1:0] model_center_y = CENTER_RESET;
    longint plat_ref = 0;
    longint plat_off = 0;
    longint slide_ref = 0;
    longint slide_off = 0;

    t_aim_item pending_items[$];
    t_aim_result aim_expect_q[$];
    t_aim_item in_flight;
    t_aim_result predicted;
    int items_outstanding = 0;
    int errors = 0;
    int results_seen = 0;
    int queries_taken = 0;
    int updates_taken = 0;
    int ignored_taken = 0;
    int center_settings = 1;
    int burst_left = 0;
    int gap_left = 0;
    bit sender_gaps_on = 1'b1;
    int stall_pct = 25;
    int hold_left = 0;
    int holds_done = 0;
    int quiet_cycles = 0;

    function automatic longint clamp_q16(input longint v);
        if (v > Q16_MAX) return Q16_MAX;
        if (v < Q16_MIN) return Q16_MIN;
        return v;
    endfunction

    function automatic longint unsigned rounded_root(input longint unsigned n);
        longint unsigned res, bitv, rem;
        res = 0;
        bitv = 64'd1 << 62;
        rem = n;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        if (rem > res) res = res + 1;
        return res;
    endfunction

    // Vectoring CORDIC; the left half plane is first rotated by a right angle.
    function automatic longint polar_angle(input longint nx, input longint ny);
        longint x, y, z, t, xs, ys;
        int n, i;
        if (ny == 0 && nx <= 0) return 0;
        x = nx * 65536;
        y = ny * 65536;
        z = 0;
        if (nx < 0) begin
            t = x;
            if (ny > 0) begin
                x = y;
                y = -t;
                z = RIGHT_ANGLE_Q30;
            end else begin
                x = -y;
                y = t;
                z = -RIGHT_ANGLE_Q30;
            end
        end
        n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        for (i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[i];
            end
        end
        return (z + 8192) >>> 14;
    endfunction

    // Advances the shadow state by one input transfer; returns 1 when a result is due.
    function automatic bit predict_aim(input t_aim_item it, output t_aim_result r);
        longint pos, nx, ny, radius, diff, num, slide;
        pos = longint'(it.pos);
        r = '0;
        if (it.cmd == CMD_PLATFORM) begin
            if (plat_ref == 0) plat_ref = pos;
            plat_off = clamp_q16(pos - plat_ref);
            return 1'b0;
        end
        if (it.cmd == CMD_SLIDE) begin
            if (slide_ref == 0) slide_ref = pos;
            slide_off = clamp_q16(pos - slide_ref);
            return 1'b0;
        end
        if (it.cmd != CMD_QUERY) return 1'b0;
        nx = longint'(it.tx) - longint'(model_center_x);
        ny = longint'(it.ty) - longint'(model_center_y);
        radius = longint'(rounded_root(longint'(nx * nx + ny * ny) << 32));
        diff = radius - slide_off;
        num = 2 * diff + 5;
        slide = num / 10;
        if ((num % 10) != 0 && num < 0) slide = slide - 1;
        r.platform = 32'(clamp_q16(polar_angle(nx, ny) - plat_off));
        r.color = 32'(clamp_q16(slide));
        r.drop = 32'(clamp_q16(slide + DROP_OFFSET_Q16));
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        errors++;
    endtask

    task automatic queue_item(input logic [1:0] cmd, input logic [31:0] pos,
                              input logic [9:0] tx, input logic [9:0] ty);
        t_aim_item it;
        it.cmd = cmd;
        it.pos = pos;
        it.tx = tx;
        it.ty = ty;
        pending_items.push_back(it);
        items_outstanding++;
    endtask

    function automatic logic [9:0] random_coord(input logic [9:0] center);
        case ($urandom_range(0, 7))
            0: return center;
            1: return ($urandom_range(0, 1) == 0) ? 10'd0 : 10'd1023;
            2: return 10'(int'(center) + $urandom_range(0, 6) - 3);
            default: return 10'($urandom_range(0, 1023));
        endcase
    endfunction

    function automatic t_aim_item random_item(input logic [9:0] cx, input logic [9:0] cy);
        t_aim_item it;
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 10) it.cmd = CMD_QUERY;
        else if (sel < 14) it.cmd = CMD_PLATFORM;
        else if (sel < 18) it.cmd = CMD_SLIDE;
        else it.cmd = CMD_UNUSED;
        case ($urandom_range(0, 5))
            0: it.pos = 32'($urandom_range(0, 262143)) - 32'sd131072;
            1: it.pos = ($urandom_range(0, 1) == 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            2: it.pos = '0;
            default: it.pos = $urandom;
        endcase
        if (it.cmd == CMD_QUERY) begin
            it.tx = random_coord(cx);
            it.ty = random_coord(cy);
        end else begin
            it.tx = 10'($urandom);
            it.ty = 10'($urandom);
        end
        return it;
    endfunction

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COORD_W-1:0] val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_CENTER_X) model_center_x = val;
        else if (idx == CFG_CENTER_Y) model_center_y = val;
    endtask

    // Updates leave no trace on the result side, so a quiet spell follows.
    task automatic wait_drained();
        @(posedge i_clk);
        while (items_outstanding != 0 || aim_expect_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_centers(input logic [9:0] cx, input logic [9:0] cy);
        cfg_write(CFG_CENTER_X, cx);
        cfg_write(CFG_CENTER_Y, cy);
        center_settings++;
    endtask

    // Input driver: bursts of transfers separated by random gaps unless gaps are off.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (predict_aim(in_flight, predicted)) aim_expect_q.push_back(predicted);
                if (in_flight.cmd == CMD_QUERY) queries_taken++;
                else if (in_flight.cmd == CMD_UNUSED) ignored_taken++;
                else updates_taken++;
                items_outstanding--;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() != 0) begin
                    in_flight = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {4'b0000, in_flight.ty, in_flight.tx, in_flight.pos};
                    s_axis_tuser <= in_flight.cmd;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = sender_gaps_on ? $urandom_range(1, 20) : 0;
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result receiver: random stalls plus two long hold-offs that back up the input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else if (holds_done < 2 && results_seen >= 60 + 260 * holds_done) begin
            holds_done++;
            hold_left = LONG_HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_aim_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (aim_expect_q.size() == 0) begin
                report_mismatch($sformatf("result %h with no query pending", m_axis_tdata));
            end else begin
                want = aim_expect_q.pop_front();
                if (m_axis_tdata[31:0] !== want.platform)
                    report_mismatch($sformatf("platform_rotation expected %08h got %08h",
                                              want.platform, m_axis_tdata[31:0]));
                if (m_axis_tdata[63:32] !== want.color)
                    report_mismatch($sformatf("color_slide_rotation expected %08h got %08h",
                                              want.color, m_axis_tdata[63:32]));
                if (m_axis_tdata[95:64] !== want.drop)
                    report_mismatch($sformatf("drop_slide_rotation expected %08h got %08h",
                                              want.drop, m_axis_tdata[95:64]));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results still due",
                     quiet_cycles, aim_expect_q.size());
            $display("** polar_aim_with_zero_reference_top: FAILED **");
            $finish;
        end
    end

    initial begin
        int ph, counted;
        logic [9:0] cx, cy;
        t_aim_item it;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset centers; zero references and offset saturation on both axes.
        queue_item(CMD_QUERY, 32'd0, 10'd512, 10'd512);
        queue_item(CMD_QUERY, 32'd0, 10'd100, 10'd512);
        queue_item(CMD_QUERY, 32'd0, 10'd1023, 10'd512);
        queue_item(CMD_QUERY, 32'd0, 10'd0, 10'd0);
        queue_item(CMD_QUERY, 32'd0, 10'd1023, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd0, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd512, 10'd0);
        queue_item(CMD_PLATFORM, 32'd0, 10'd0, 10'd0);
        queue_item(CMD_SLIDE, 32'd0, 10'd1023, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd700, 10'd300);
        queue_item(CMD_PLATFORM, 32'h7FFF_0000, 10'd0, 10'd0);
        queue_item(CMD_PLATFORM, 32'h8000_0000, 10'd0, 10'd0);
        queue_item(CMD_SLIDE, 32'h8001_0000, 10'd0, 10'd0);
        queue_item(CMD_SLIDE, 32'h7FFF_FFFF, 10'd0, 10'd0);
        queue_item(CMD_QUERY, 32'd0, 10'd300, 10'd700);
        queue_item(CMD_PLATFORM, 32'h7FFF_FFFF, 10'd0, 10'd0);
        queue_item(CMD_UNUSED, 32'hFFFF_FFFF, 10'd1023, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd1023, 10'd0);
        wait_drained();

        // Extreme centers; writes to unused indexes must change nothing.
        set_centers(10'd0, 10'd0);
        cfg_write(CFG_SPARE_A, 10'd1023);
        cfg_write(CFG_SPARE_B, 10'd700);
        queue_item(CMD_QUERY, 32'd0, 10'd0, 10'd0);
        queue_item(CMD_QUERY, 32'd0, 10'd1023, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd0, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd1023, 10'd0);
        wait_drained();
        set_centers(10'd1023, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd0, 10'd0);
        queue_item(CMD_QUERY, 32'd0, 10'd1023, 10'd1023);
        queue_item(CMD_QUERY, 32'd0, 10'd0, 10'd1023);
        wait_drained();

        for (ph = 0; ph < RANDOM_PHASES; ph++) begin
            if (ph == 0) begin
                cx = 10'd0;
                cy = 10'd1023;
            end else if (ph == 1) begin
                cx = 10'd1023;
                cy = 10'd0;
            end else if (ph == 3) begin
                cx = CENTER_RESET;
                cy = CENTER_RESET;
            end else begin
                cx = 10'($urandom);
                cy = 10'($urandom);
            end
            set_centers(cx, cy);
            // One phase runs flat out on both sides.
            sender_gaps_on = (ph != 2);
            stall_pct = (ph == 2) ? 0 : $urandom_range(10, 60);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it = random_item(cx, cy);
                queue_item(it.cmd, it.pos, it.tx, it.ty);
                counted++;
            end
            wait_drained();
        end

        $display("Covered %0d aim queries, %0d axis updates and %0d ignored commands",
                 queries_taken, updates_taken, ignored_taken);
        $display("over %0d center settings; %0d results checked, %0d mismatches.",
                 center_settings, results_seen, errors);
        if (errors == 0) begin
            $display("** polar_aim_with_zero_reference_top: PASSED **");
        end else begin
            $display("** polar_aim_with_zero_reference_top: FAILED **");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/pawzr_pkg.sv
hw/rtl/pawzr_ctrl.sv
hw/rtl/pawzr_dp.sv
hw/rtl/polar_aim_with_zero_reference_top.sv
dv/tb_top.sv
